@@ hw/rtl/stc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source tokenizer package
// Shared types, token kinds, error codes and operator tables.
// ----------------------------------------------------------------------------
package stc_pkg;

  // Lexer modes; the pending operator modes run from MODE_MINUS to MODE_COLON.
  typedef enum logic [4:0] {
    MODE_IDLE  = 5'd0,
    MODE_IDENT = 5'd1,
    MODE_INT   = 5'd2,
    MODE_FLOAT = 5'd3,
    MODE_STR   = 5'd4,
    MODE_CHAR1 = 5'd5,
    MODE_CHAR2 = 5'd6,
    MODE_MINUS = 5'd7,
    MODE_EQ    = 5'd8,
    MODE_BANG  = 5'd9,
    MODE_LT    = 5'd10,
    MODE_GT    = 5'd11,
    MODE_COLON = 5'd12,
    MODE_SLASH = 5'd13,
    MODE_LINE  = 5'd14,
    MODE_BLOCK = 5'd15,
    MODE_BSTAR = 5'd16
  } stc_mode_e;

  // Character classes, as seen at the start of a token.
  typedef enum logic [2:0] {
    CL_SPACE = 3'd0,
    CL_WORD  = 3'd1,
    CL_DIGIT = 3'd2,
    CL_STR   = 3'd3,
    CL_CHR   = 3'd4,
    CL_OP1   = 3'd5,
    CL_OP2   = 3'd6,
    CL_BAD   = 3'd7
  } stc_class_e;

  typedef enum logic [2:0] {
    ERR_STR_NL     = 3'd0,
    ERR_STR_OPEN   = 3'd1,
    ERR_CHR_EMPTY  = 3'd2,
    ERR_CHR_NL     = 3'd3,
    ERR_CHR_OPEN   = 3'd4,
    ERR_LINE_OPEN  = 3'd5,
    ERR_BLOCK_OPEN = 3'd6,
    ERR_BAD_CHAR   = 3'd7
  } stc_err_e;

  localparam logic [4:0] KIND_IDENT  = 5'd0;
  localparam logic [4:0] KIND_INT    = 5'd1;
  localparam logic [4:0] KIND_FLOAT  = 5'd2;
  localparam logic [4:0] KIND_STRING = 5'd3;
  localparam logic [4:0] KIND_CHAR   = 5'd4;
  localparam logic [4:0] KIND_PLUS   = 5'd5;
  localparam logic [4:0] KIND_ARROW  = 5'd6;
  localparam logic [4:0] KIND_MINUS  = 5'd7;
  localparam logic [4:0] KIND_STAR   = 5'd8;
  localparam logic [4:0] KIND_SLASH  = 5'd9;
  localparam logic [4:0] KIND_EQEQ   = 5'd10;
  localparam logic [4:0] KIND_ASSIGN = 5'd11;
  localparam logic [4:0] KIND_NE     = 5'd12;
  localparam logic [4:0] KIND_BANG   = 5'd13;
  localparam logic [4:0] KIND_LE     = 5'd14;
  localparam logic [4:0] KIND_LT     = 5'd15;
  localparam logic [4:0] KIND_GE     = 5'd16;
  localparam logic [4:0] KIND_GT     = 5'd17;
  localparam logic [4:0] KIND_DOT    = 5'd18;
  localparam logic [4:0] KIND_DEFINE = 5'd19;
  localparam logic [4:0] KIND_COLON  = 5'd20;
  localparam logic [4:0] KIND_SEMI   = 5'd21;
  localparam logic [4:0] KIND_COMMA  = 5'd22;
  localparam logic [4:0] KIND_LPAREN = 5'd23;
  localparam logic [4:0] KIND_RPAREN = 5'd24;
  localparam logic [4:0] KIND_LBRACE = 5'd25;
  localparam logic [4:0] KIND_RBRACE = 5'd26;
  localparam logic [4:0] KIND_LBRACK = 5'd27;
  localparam logic [4:0] KIND_RBRACK = 5'd28;
  localparam logic [4:0] KIND_AMP    = 5'd29;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic [7:0] code;
    logic       cvalid;
    logic       eoi;
    stc_class_e cls;
    logic [4:0] op_kind;
    stc_mode_e  op_mode;
  } stc_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
    logic [7:0]  cval;
    logic        err;
    stc_err_e    code;
    logic        done;
    logic        last;
  } stc_result_t;

  function automatic stc_result_t tok_res(logic [4:0] kind, logic [31:0] start,
                                          logic [15:0] len, logic [7:0] cval);
    stc_result_t r;
    r       = '0;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.cval  = cval;
    return r;
  endfunction

  function automatic stc_result_t err_res(stc_err_e code, logic [31:0] start);
    stc_result_t r;
    r       = '0;
    r.start = start;
    r.err   = 1'b1;
    r.code  = code;
    r.done  = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] pend_second(stc_mode_e m);
    return (m == MODE_MINUS) ? CH_GT : CH_EQ;
  endfunction

  function automatic logic [4:0] pend_double(stc_mode_e m);
    logic [4:0] k;
    unique case (m)
      MODE_MINUS: k = KIND_ARROW;
      MODE_EQ:    k = KIND_EQEQ;
      MODE_BANG:  k = KIND_NE;
      MODE_LT:    k = KIND_LE;
      MODE_GT:    k = KIND_GE;
      MODE_COLON: k = KIND_DEFINE;
      default:    k = KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pend_single(stc_mode_e m);
    logic [4:0] k;
    unique case (m)
      MODE_MINUS: k = KIND_MINUS;
      MODE_EQ:    k = KIND_ASSIGN;
      MODE_BANG:  k = KIND_BANG;
      MODE_LT:    k = KIND_LT;
      MODE_GT:    k = KIND_GT;
      MODE_COLON: k = KIND_COLON;
      default:    k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/stc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer front end
// Classifies each incoming byte for the lexer back end.
// ----------------------------------------------------------------------------
module stc_front (
  input  logic              [7:0] char_code_i,
  input  logic                    char_valid_i,
  input  logic                    end_of_input_i,
  output stc_pkg::stc_item_t      item_o
);

  stc_pkg::stc_class_e cls;
  logic [4:0]          op_kind;
  stc_pkg::stc_mode_e  op_mode;

  always_comb begin
    cls     = stc_pkg::CL_BAD;
    op_kind = stc_pkg::KIND_IDENT;
    op_mode = stc_pkg::MODE_IDLE;
    unique case (char_code_i) inside
      8'h20, [8'h09:8'h0D]: cls = stc_pkg::CL_SPACE;
      [8'h41:8'h5A], [8'h61:8'h7A], stc_pkg::CH_UNDER: cls = stc_pkg::CL_WORD;
      [8'h30:8'h39]:     cls = stc_pkg::CL_DIGIT;
      stc_pkg::CH_DQUOTE: cls = stc_pkg::CL_STR;
      stc_pkg::CH_SQUOTE: cls = stc_pkg::CL_CHR;
      8'h2B: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_PLUS;   end
      stc_pkg::CH_STAR: begin
        cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_STAR;
      end
      stc_pkg::CH_DOT: begin
        cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_DOT;
      end
      8'h3B: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_SEMI;   end
      8'h2C: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_COMMA;  end
      8'h28: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_LPAREN; end
      8'h29: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_RPAREN; end
      8'h7B: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_LBRACE; end
      8'h7D: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_RBRACE; end
      8'h5B: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_LBRACK; end
      8'h5D: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_RBRACK; end
      8'h26: begin cls = stc_pkg::CL_OP1; op_kind = stc_pkg::KIND_AMP;    end
      8'h2D: begin cls = stc_pkg::CL_OP2; op_mode = stc_pkg::MODE_MINUS;  end
      stc_pkg::CH_EQ: begin
        cls = stc_pkg::CL_OP2; op_mode = stc_pkg::MODE_EQ;
      end
      8'h21: begin cls = stc_pkg::CL_OP2; op_mode = stc_pkg::MODE_BANG;   end
      8'h3C: begin cls = stc_pkg::CL_OP2; op_mode = stc_pkg::MODE_LT;     end
      stc_pkg::CH_GT: begin
        cls = stc_pkg::CL_OP2; op_mode = stc_pkg::MODE_GT;
      end
      8'h3A: begin cls = stc_pkg::CL_OP2; op_mode = stc_pkg::MODE_COLON;  end
      stc_pkg::CH_SLASH: begin
        cls = stc_pkg::CL_OP2; op_mode = stc_pkg::MODE_SLASH;
      end
      default: cls = stc_pkg::CL_BAD;
    endcase
  end

  always_comb begin
    item_o.code    = char_code_i;
    item_o.cvalid  = char_valid_i;
    item_o.eoi     = end_of_input_i;
    item_o.cls     = cls;
    item_o.op_kind = op_kind;
    item_o.op_mode = op_mode;
  end

endmodule

@@ hw/rtl/stc_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer request queue
// Two-entry queue between the front end and the lexer back end.
// ----------------------------------------------------------------------------
module stc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  stc_pkg::stc_item_t item_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output stc_pkg::stc_item_t item_o
);

  stc_pkg::stc_item_t mem_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != 2'd0)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> count_q != 2'd2)
    else $error("queue pushed while full");

endmodule

@@ hw/rtl/stc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer back end
// Lexer state machine, result sequencer and output register.
// ----------------------------------------------------------------------------
module stc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  stc_pkg::stc_item_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stc_pkg::stc_result_t out_o
);

  stc_pkg::stc_mode_e mode_q, mode_d;
  logic [31:0]        pos_q, pos_d;
  logic [31:0]        start_q, start_d;
  logic [15:0]        len_q, len_d;
  logic [7:0]         lit_q, lit_d;
  logic               halt_q, halt_d;
  logic [1:0]         idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  stc_pkg::stc_result_t out_q, out_d;

  stc_pkg::stc_result_t res [4];
  logic [3:0]           res_vld;
  stc_pkg::stc_result_t list [3];
  logic [2:0]           cnt;
  logic                 live;
  logic                 restart;
  logic                 flush_err;
  logic [15:0]          len_grow;
  logic                 load;
  logic                 last;

  assign len_grow = (len_q != 16'hFFFF) ? len_q + 16'd1 : len_q;

  // Lexer step: the token or error closed by this byte, the token or error
  // started by it, at end of input the flushed token or error and end marker.
  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    start_d   = start_q;
    len_d     = len_q;
    lit_d     = lit_q;
    halt_d    = halt_q;
    res       = '{default: '0};
    res_vld   = 4'b0000;
    restart   = 1'b0;
    flush_err = 1'b0;
    live      = head_valid_i && head_i.cvalid && !halt_q;

    if (live) begin
      unique case (mode_q)
        stc_pkg::MODE_IDLE: restart = 1'b1;
        stc_pkg::MODE_IDENT: begin
          if (head_i.cls == stc_pkg::CL_WORD || head_i.cls == stc_pkg::CL_DIGIT) begin
            len_d = len_grow;
          end else begin
            res[0] = stc_pkg::tok_res(stc_pkg::KIND_IDENT, start_q, len_q, 8'd0);
            res_vld[0] = 1'b1;
            mode_d = stc_pkg::MODE_IDLE;
            restart = 1'b1;
          end
        end
        stc_pkg::MODE_INT: begin
          if (head_i.cls == stc_pkg::CL_DIGIT) begin
            len_d = len_grow;
          end else if (head_i.code == stc_pkg::CH_DOT) begin
            len_d  = len_grow;
            mode_d = stc_pkg::MODE_FLOAT;
          end else begin
            res[0] = stc_pkg::tok_res(stc_pkg::KIND_INT, start_q, len_q, 8'd0);
            res_vld[0] = 1'b1;
            mode_d = stc_pkg::MODE_IDLE;
            restart = 1'b1;
          end
        end
        stc_pkg::MODE_FLOAT: begin
          if (head_i.cls == stc_pkg::CL_DIGIT) begin
            len_d = len_grow;
          end else begin
            res[0] = stc_pkg::tok_res(stc_pkg::KIND_FLOAT, start_q, len_q, 8'd0);
            res_vld[0] = 1'b1;
            mode_d = stc_pkg::MODE_IDLE;
            restart = 1'b1;
          end
        end
        stc_pkg::MODE_STR: begin
          if (head_i.code == stc_pkg::CH_DQUOTE) begin
            res[0] = stc_pkg::tok_res(stc_pkg::KIND_STRING, start_q, len_q, 8'd0);
            res_vld[0] = 1'b1;
            mode_d = stc_pkg::MODE_IDLE;
          end else if (head_i.code == stc_pkg::CH_NL) begin
            res[0] = stc_pkg::err_res(stc_pkg::ERR_STR_NL, start_q);
            res_vld[0] = 1'b1;
            halt_d = 1'b1;
            mode_d = stc_pkg::MODE_IDLE;
          end else begin
            len_d = len_grow;
          end
        end
        stc_pkg::MODE_CHAR1: begin
          if (head_i.code == stc_pkg::CH_SQUOTE) begin
            res[0] = stc_pkg::err_res(stc_pkg::ERR_CHR_EMPTY, start_q);
            res_vld[0] = 1'b1;
            halt_d = 1'b1;
            mode_d = stc_pkg::MODE_IDLE;
          end else if (head_i.code == stc_pkg::CH_NL) begin
            res[0] = stc_pkg::err_res(stc_pkg::ERR_CHR_NL, start_q);
            res_vld[0] = 1'b1;
            halt_d = 1'b1;
            mode_d = stc_pkg::MODE_IDLE;
          end else begin
            lit_d  = head_i.code;
            mode_d = stc_pkg::MODE_CHAR2;
          end
        end
        stc_pkg::MODE_CHAR2: begin
          if (head_i.code == stc_pkg::CH_SQUOTE) begin
            res[0] = stc_pkg::tok_res(stc_pkg::KIND_CHAR, start_q, 16'd1, lit_q);
          end else begin
            res[0] = stc_pkg::err_res(stc_pkg::ERR_CHR_OPEN, start_q);
            halt_d = 1'b1;
          end
          res_vld[0] = 1'b1;
          mode_d = stc_pkg::MODE_IDLE;
        end
        stc_pkg::MODE_SLASH: begin
          if (head_i.code == stc_pkg::CH_SLASH) begin
            mode_d = stc_pkg::MODE_LINE;
          end else if (head_i.code == stc_pkg::CH_STAR) begin
            mode_d = stc_pkg::MODE_BLOCK;
          end else begin
            res[0] = stc_pkg::tok_res(stc_pkg::KIND_SLASH, start_q, 16'd1, 8'd0);
            res_vld[0] = 1'b1;
            mode_d = stc_pkg::MODE_IDLE;
            restart = 1'b1;
          end
        end
        stc_pkg::MODE_LINE: begin
          if (head_i.code == stc_pkg::CH_NL) mode_d = stc_pkg::MODE_IDLE;
        end
        stc_pkg::MODE_BLOCK: begin
          if (head_i.code == stc_pkg::CH_STAR) mode_d = stc_pkg::MODE_BSTAR;
        end
        stc_pkg::MODE_BSTAR: begin
          if (head_i.code == stc_pkg::CH_SLASH) begin
            mode_d = stc_pkg::MODE_IDLE;
          end else if (head_i.code != stc_pkg::CH_STAR) begin
            mode_d = stc_pkg::MODE_BLOCK;
          end
        end
        stc_pkg::MODE_MINUS, stc_pkg::MODE_EQ, stc_pkg::MODE_BANG,
        stc_pkg::MODE_LT, stc_pkg::MODE_GT, stc_pkg::MODE_COLON: begin
          res_vld[0] = 1'b1;
          mode_d = stc_pkg::MODE_IDLE;
          if (head_i.code == stc_pkg::pend_second(mode_q)) begin
            res[0] = stc_pkg::tok_res(stc_pkg::pend_double(mode_q), start_q, 16'd2, 8'd0);
          end else begin
            res[0] = stc_pkg::tok_res(stc_pkg::pend_single(mode_q), start_q, 16'd1, 8'd0);
            restart = 1'b1;
          end
        end
        default: begin
          mode_d  = stc_pkg::MODE_IDLE;
          restart = 1'b1;
        end
      endcase
    end

    // The byte starts afresh between tokens.
    if (restart) begin
      start_d = pos_q;
      len_d   = 16'd0;
      lit_d   = 8'd0;
      case (head_i.cls)
        stc_pkg::CL_SPACE: ;
        stc_pkg::CL_WORD: begin
          len_d  = 16'd1;
          mode_d = stc_pkg::MODE_IDENT;
        end
        stc_pkg::CL_DIGIT: begin
          len_d  = 16'd1;
          mode_d = stc_pkg::MODE_INT;
        end
        stc_pkg::CL_STR: mode_d = stc_pkg::MODE_STR;
        stc_pkg::CL_CHR: mode_d = stc_pkg::MODE_CHAR1;
        stc_pkg::CL_OP1: begin
          res[1] = stc_pkg::tok_res(head_i.op_kind, pos_q, 16'd1, 8'd0);
          res_vld[1] = 1'b1;
        end
        stc_pkg::CL_OP2: mode_d = head_i.op_mode;
        default: begin
          res[1] = stc_pkg::err_res(stc_pkg::ERR_BAD_CHAR, pos_q);
          res_vld[1] = 1'b1;
          halt_d = 1'b1;
        end
      endcase
    end

    if (live && pos_q != 32'hFFFF_FFFF) begin
      pos_d = pos_q + 32'd1;
    end

    if (head_valid_i && head_i.eoi) begin
      if (!halt_d) begin
        case (mode_d)
          stc_pkg::MODE_IDLE: ;
          stc_pkg::MODE_IDENT: begin
            res[2] = stc_pkg::tok_res(stc_pkg::KIND_IDENT, start_d, len_d, 8'd0);
            res_vld[2] = 1'b1;
          end
          stc_pkg::MODE_INT: begin
            res[2] = stc_pkg::tok_res(stc_pkg::KIND_INT, start_d, len_d, 8'd0);
            res_vld[2] = 1'b1;
          end
          stc_pkg::MODE_FLOAT: begin
            res[2] = stc_pkg::tok_res(stc_pkg::KIND_FLOAT, start_d, len_d, 8'd0);
            res_vld[2] = 1'b1;
          end
          stc_pkg::MODE_STR: begin
            res[2] = stc_pkg::err_res(stc_pkg::ERR_STR_OPEN, start_d);
            res_vld[2] = 1'b1;
            flush_err = 1'b1;
          end
          stc_pkg::MODE_CHAR1, stc_pkg::MODE_CHAR2: begin
            res[2] = stc_pkg::err_res(stc_pkg::ERR_CHR_OPEN, start_d);
            res_vld[2] = 1'b1;
            flush_err = 1'b1;
          end
          stc_pkg::MODE_SLASH: begin
            res[2] = stc_pkg::tok_res(stc_pkg::KIND_SLASH, start_d, 16'd1, 8'd0);
            res_vld[2] = 1'b1;
          end
          stc_pkg::MODE_LINE: begin
            res[2] = stc_pkg::err_res(stc_pkg::ERR_LINE_OPEN, start_d);
            res_vld[2] = 1'b1;
            flush_err = 1'b1;
          end
          stc_pkg::MODE_BLOCK, stc_pkg::MODE_BSTAR: begin
            res[2] = stc_pkg::err_res(stc_pkg::ERR_BLOCK_OPEN, start_d);
            res_vld[2] = 1'b1;
            flush_err = 1'b1;
          end
          default: begin
            res[2] = stc_pkg::tok_res(stc_pkg::pend_single(mode_d), start_d, 16'd1, 8'd0);
            res_vld[2] = 1'b1;
          end
        endcase
        if (!flush_err) begin
          res[3]      = stc_pkg::tok_res(stc_pkg::KIND_IDENT, pos_d, 16'd0, 8'd0);
          res[3].done = 1'b1;
          res_vld[3]  = 1'b1;
        end
      end
      // End of input returns the lexer to its reset state.
      mode_d  = stc_pkg::MODE_IDLE;
      pos_d   = 32'd0;
      start_d = 32'd0;
      len_d   = 16'd0;
      lit_d   = 8'd0;
      halt_d  = 1'b0;
    end
  end

  // Pack the results of this request in order.
  always_comb begin
    list = '{default: '0};
    cnt  = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (res_vld[i] && cnt != 3'd3) begin
        list[cnt[1:0]] = res[i];
        cnt = cnt + 3'd1;
      end
    end
  end

  always_comb begin
    load  = head_valid_i && (cnt != 3'd0) && (!out_valid_q || out_ready_i);
    last  = ({1'b0, idx_q} == cnt - 3'd1);
    pop_o = head_valid_i && ((cnt == 3'd0) || (load && last));
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = 2'd0;
    end else if (load) begin
      idx_d = idx_q + 2'd1;
    end
    out_d = out_q;
    if (load) begin
      out_d      = list[idx_q];
      out_d.last = last;
    end
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= stc_pkg::MODE_IDLE;
      pos_q       <= 32'd0;
      start_q     <= 32'd0;
      len_q       <= 16'd0;
      lit_q       <= 8'd0;
      halt_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        len_q   <= len_d;
        lit_q   <= lit_d;
        halt_q  <= halt_d;
      end
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   halt_q |-> mode_q == stc_pkg::MODE_IDLE)
    else $error("lexer halted outside idle mode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   idx_q != 2'd0 |-> head_valid_i)
    else $error("result index advanced without a request at the head");
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q != 2'd3)
    else $error("result index out of range");

endmodule

@@ hw/rtl/source_char_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source character tokenizer
// Streaming lexer: one source byte in, token descriptors out.
// ----------------------------------------------------------------------------
// A request carrying one byte is accepted every cycle as long as each request
// yields at most one result and out_ready_i does not hold the output back.
// A request that closes a token and opens another, or ends the input, yields
// up to three results, and these leave through the single output register one
// per cycle while out_ready_i allows; the lexer moves on to the next request
// only once the last of them is loaded. A request is first registered in the
// two-entry request queue and its results then in the output register. After
// a lexical error, requests are consumed without results until end of input,
// which returns the block to its reset state.
module source_char_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        char_valid_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] start_pos_o,
  output logic [15:0] token_length_o,
  output logic [7:0]  char_value_o,
  output logic        is_error_o,
  output logic [2:0]  error_code_o,
  output logic        stream_done_o,
  output logic        last_of_run_o
);

  stc_pkg::stc_item_t   in_item;
  stc_pkg::stc_item_t   head_item;
  stc_pkg::stc_result_t result;
  logic                 q_ready;
  logic                 head_valid;
  logic                 pop;

  stc_front u_front (
    .char_code_i    (char_code_i),
    .char_valid_i   (char_valid_i),
    .end_of_input_i (end_of_input_i),
    .item_o         (in_item)
  );

  stc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && q_ready),
    .item_i  (in_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  stc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (result)
  );

  assign in_ready_o     = q_ready;
  assign token_kind_o   = result.kind;
  assign start_pos_o    = result.start;
  assign token_length_o = result.len;
  assign char_value_o   = result.cval;
  assign is_error_o     = result.err;
  assign error_code_o   = result.code;
  assign stream_done_o  = result.done;
  assign last_of_run_o  = result.last;

endmodule
